>>> sv/rsa_pkg.sv
// Package for the region sector allocator: field widths, store sizes,
// request kind codes and result status codes. No dependencies.
`default_nettype none

package rsa_pkg;

   localparam int OFF_W      = 12;                 // sector offset width
   localparam int CNT_W      = 8;                  // sector count width
   localparam int EXT_W      = OFF_W + 1;          // extent / end-of-run width
   localparam int SLOT_W     = 10;                 // slot index width
   localparam int COORD_W    = 5;                  // local column / row width
   localparam int ENTRY_W    = OFF_W + CNT_W;      // packed slot entry
   localparam int SLOTS      = 1 << SLOT_W;
   localparam int MAP_BITS   = 1 << OFF_W;
   localparam int MAP_WORDS  = MAP_BITS / 32;
   localparam int MAP_AW     = $clog2(MAP_WORDS);
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 88;                 // 32 + 32 + 8 + 12, padded to bytes
   localparam int RSP_DATA_W = 40;                 // 10 + 1 + 12 + 8 + 2, padded to bytes

   localparam logic [EXT_W-1:0] MAX_SECTORS = EXT_W'(MAP_BITS);

   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PRELOAD = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ZERO_COUNT = 2'd1,
      STATUS_NO_SPACE   = 2'd2,
      STATUS_BEYOND     = 2'd3
   } status_type;

endpackage

`default_nettype wire

>>> sv/region_sector_allocator_unit.sv
// Region sector allocator: slot table, sector bitmap and extent, run under one
// sequencer with a shared bitmap read-modify-write and run-scan unit. Uses rsa_pkg.
//
// After reset the block runs a clearing pass over all 1024 slot table entries (the
// 128 bitmap words are cleared alongside the first 128) and accepts no request
// until it ends. A lookup, a zero-count write or a preload beyond the store reads
// its slot entry and is answered without touching the bitmap. Any other request
// adds a step after freeing and one writing the slot entry, plus a bitmap read and
// write per 32-sector word touched when freeing the old run and when marking the
// new one (up to 9 words each). A write also runs a first-fit scan of 1 read and up
// to 4 steps of 8 sectors per 32-sector word below the extent, stopping at the byte
// where the run is found or the extent is passed; when nothing fits, an append step
// places the run at the extent. The scan through the single-port bitmap memory
// dominates the time of a write. One request is in work at a time; a finished
// result waits in the output register while the next request is taken.
`default_nettype none

module region_sector_allocator_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // chunk_x [31:0], chunk_z [63:32], sector_count [71:64], sector_offset [83:72]
   input  wire  [rsa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [1:0]
   input  wire  [rsa_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // slot_index [9:0], present [10], run_offset [22:11], run_count [30:23],
   // status [32:31]
   output logic [rsa_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import rsa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SLOT_RD, S_DECIDE, S_RMW_RD, S_RMW_WR, S_POST_FREE,
      S_SCAN_RD, S_SCAN_BYTE, S_APPEND, S_COMMIT, S_RESPOND
   } state_type;

   typedef enum logic {PH_FREE, PH_MARK} phase_type;

   // memories
   logic [ENTRY_W-1:0] slot_mem [SLOTS];
   logic [31:0]        map_mem  [MAP_WORDS];

   state_type               state_ff, state_in;
   phase_type               phase_ff, phase_in;
   logic [SLOT_W-1:0]       clr_ff, clr_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [OFF_W-1:0]        poff_ff, poff_in;
   logic [ENTRY_W-1:0]      entry_ff, entry_in;
   status_type              status_ff, status_in;
   logic [EXT_W-1:0]        extent_ff, extent_in;
   logic [EXT_W-1:0]        lo_ff, lo_in;
   logic [EXT_W-1:0]        hi_ff, hi_in;
   logic [MAP_AW-1:0]       word_ff, word_in;
   logic [1:0]              byte_ff, byte_in;
   logic [CNT_W-1:0]        run_ff, run_in;
   logic [OFF_W-1:0]        start_ff, start_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic [ENTRY_W-1:0]      slot_rd_ff;
   logic [31:0]             map_rd_ff;

   logic                    slot_re, slot_we;
   logic [SLOT_W-1:0]       slot_wa;
   logic [ENTRY_W-1:0]      slot_wd;
   logic                    map_re, map_we;
   logic [MAP_AW-1:0]       map_wa;
   logic [31:0]             map_wd;

   logic [OFF_W-1:0]        old_off;
   logic [CNT_W-1:0]        old_cnt;
   logic [EXT_W-1:0]        free_end, free_lo, free_hi, pre_end, app_end, hi_m1;
   logic [31:0]             rmw_mask;
   logic [CNT_W-1:0]        scan_run;
   logic [OFF_W-1:0]        scan_start;
   logic                    scan_found;
   logic [EXT_W-1:0]        scan_next;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign old_off  = slot_rd_ff[ENTRY_W-1:CNT_W];
   assign old_cnt  = slot_rd_ff[CNT_W-1:0];
   assign free_end = {1'b0, old_off} + EXT_W'(old_cnt);
   assign free_hi  = (free_end < extent_ff) ? free_end : extent_ff;
   // sector 0 holds the header and is never freed
   assign free_lo  = (old_off == '0) ? EXT_W'(1) : {1'b0, old_off};
   assign pre_end  = {1'b0, poff_ff} + EXT_W'(cnt_ff);
   assign app_end  = extent_ff + EXT_W'(cnt_ff);
   assign hi_m1    = hi_ff - EXT_W'(1);

   // bits of the current word that fall in [lo, hi)
   always_comb begin
      logic [EXT_W-1:0] pos;
      for (int b = 0; b < 32; b++) begin
         pos = {1'b0, word_ff, 5'(b)};
         rmw_mask[b] = (pos >= lo_ff) && (pos < hi_ff);
      end
   end

   // first-fit step over eight sectors of the current word
   always_comb begin
      logic [7:0]       bits;
      logic [EXT_W-1:0] pos;
      bits       = map_rd_ff[{byte_ff, 3'b000} +: 8];
      scan_run   = run_ff;
      scan_start = start_ff;
      scan_found = 1'b0;
      for (int k = 0; k < 8; k++) begin
         pos = {1'b0, word_ff, byte_ff, 3'(k)};
         if (!scan_found && (pos < extent_ff)) begin
            if (!bits[k]) begin
               if (scan_run == '0) begin
                  scan_start = pos[OFF_W-1:0];
               end
               scan_run = scan_run + CNT_W'(1);
               if (scan_run >= cnt_ff) begin
                  scan_found = 1'b1;
               end
            end else begin
               scan_run = '0;
            end
         end
      end
      scan_next = {1'b0, word_ff, byte_ff, 3'b111} + EXT_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      poff_in       = poff_ff;
      entry_in      = entry_ff;
      status_in     = status_ff;
      extent_in     = extent_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      word_in       = word_ff;
      byte_in       = byte_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      slot_re = 1'b0;
      slot_we = 1'b0;
      slot_wa = idx_ff;
      slot_wd = entry_ff;
      map_re  = 1'b0;
      map_we  = 1'b0;
      map_wa  = word_ff;
      map_wd  = (phase_ff == PH_MARK) ? (map_rd_ff | rmw_mask) : (map_rd_ff & ~rmw_mask);

      case (state_ff)
         S_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_ff;
            slot_wd = '0;
            if (clr_ff[SLOT_W-1:MAP_AW] == '0) begin
               map_we = 1'b1;
               map_wa = clr_ff[MAP_AW-1:0];
               map_wd = (clr_ff == '0) ? 32'd1 : 32'd0;
            end
            clr_in = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               idx_in   = {req_tdata[32 +: COORD_W], req_tdata[0 +: COORD_W]};
               cnt_in   = req_tdata[64 +: CNT_W];
               poff_in  = req_tdata[72 +: OFF_W];
               state_in = S_SLOT_RD;
            end
         end
         S_SLOT_RD: begin
            slot_re  = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            entry_in  = slot_rd_ff;
            status_in = STATUS_OK;
            if (kind_ff != KIND_WRITE && kind_ff != KIND_PRELOAD) begin
               state_in = S_RESPOND;
            end else if (kind_ff == KIND_WRITE && cnt_ff == '0) begin
               status_in = STATUS_ZERO_COUNT;
               state_in  = S_RESPOND;
            end else if (kind_ff == KIND_PRELOAD && pre_end > MAX_SECTORS) begin
               status_in = STATUS_BEYOND;
               state_in  = S_RESPOND;
            end else if (slot_rd_ff != '0 && free_lo < free_hi) begin
               lo_in    = free_lo;
               hi_in    = free_hi;
               word_in  = free_lo[OFF_W-1:5];
               phase_in = PH_FREE;
               state_in = S_RMW_RD;
            end else begin
               state_in = S_POST_FREE;
            end
         end
         S_RMW_RD: begin
            map_re   = 1'b1;
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            map_we = 1'b1;
            if (word_ff == hi_m1[OFF_W-1:5]) begin
               state_in = (phase_ff == PH_FREE) ? S_POST_FREE : S_COMMIT;
            end else begin
               word_in  = word_ff + MAP_AW'(1);
               state_in = S_RMW_RD;
            end
         end
         S_POST_FREE: begin
            if (kind_ff == KIND_WRITE) begin
               word_in  = '0;
               byte_in  = '0;
               run_in   = '0;
               state_in = S_SCAN_RD;
            end else begin
               entry_in = {poff_ff, cnt_ff};
               state_in = S_COMMIT;
               if ({poff_ff, cnt_ff} != '0) begin
                  if (pre_end > extent_ff) begin
                     extent_in = pre_end;
                  end
                  if (cnt_ff != '0) begin
                     lo_in    = {1'b0, poff_ff};
                     hi_in    = pre_end;
                     word_in  = poff_ff[OFF_W-1:5];
                     phase_in = PH_MARK;
                     state_in = S_RMW_RD;
                  end
               end
            end
         end
         S_SCAN_RD: begin
            map_re   = 1'b1;
            byte_in  = '0;
            state_in = S_SCAN_BYTE;
         end
         S_SCAN_BYTE: begin
            run_in   = scan_run;
            start_in = scan_start;
            if (scan_found) begin
               entry_in = {scan_start, cnt_ff};
               lo_in    = {1'b0, scan_start};
               hi_in    = {1'b0, scan_start} + EXT_W'(cnt_ff);
               word_in  = scan_start[OFF_W-1:5];
               phase_in = PH_MARK;
               state_in = S_RMW_RD;
            end else if (scan_next >= extent_ff) begin
               state_in = S_APPEND;
            end else if (byte_ff == 2'd3) begin
               word_in  = word_ff + MAP_AW'(1);
               state_in = S_SCAN_RD;
            end else begin
               byte_in = byte_ff + 2'd1;
            end
         end
         S_APPEND: begin
            if (app_end > MAX_SECTORS) begin
               // old run stays freed and the slot drops out
               entry_in  = '0;
               status_in = STATUS_NO_SPACE;
               state_in  = S_COMMIT;
            end else begin
               entry_in  = {extent_ff[OFF_W-1:0], cnt_ff};
               lo_in     = extent_ff;
               hi_in     = app_end;
               word_in   = extent_ff[OFF_W-1:5];
               extent_in = app_end;
               phase_in  = PH_MARK;
               state_in  = S_RMW_RD;
            end
         end
         S_COMMIT: begin
            slot_we  = 1'b1;
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {7'b0, status_ff, entry_ff[CNT_W-1:0],
                                entry_ff[ENTRY_W-1:CNT_W], (entry_ff != '0), idx_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         extent_ff     <= EXT_W'(1);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         extent_ff     <= extent_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      phase_ff     <= phase_in;
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      poff_ff      <= poff_in;
      entry_ff     <= entry_in;
      status_ff    <= status_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      word_ff      <= word_in;
      byte_ff      <= byte_in;
      run_ff       <= run_in;
      start_ff     <= start_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      if (map_re) begin
         map_rd_ff <= map_mem[word_ff];
      end
   end

endmodule

`default_nettype wire
